// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is asserted.
`define A_CHK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// Clocked check that also holds during reset.
`define A_CHK_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");
`else
`define A_CHK(lbl, prop)
`define A_CHK_ALWAYS(lbl, prop)
`endif
`endif

// ===== src/mi3_pkg.sv =====
`default_nettype none
package mi3_pkg;
	// Quotient bits produced by the divider pipeline, one per stage.
	localparam int QB = 32;
	// Stages in front of the divider: products, cofactors, det partials,
	// det sum, magnitudes, threshold and overflow checks.
	localparam int NF = 6;
	localparam int NS = NF + QB;
	localparam int EW = 32;
	localparam int CW = 64;
	localparam int MW = 63;
	localparam int DW = 98;
	localparam int AW = 97;
	localparam int RW = 95;
	localparam int TW = 63;
	localparam logic [TW-1:0] THR_RESET = 63'd4295;
	localparam logic [0:0] ADDR_THR = 1'b0;

	// Element indexes a, b, c, d of each cofactor m[a]*m[b] - m[c]*m[d].
	localparam int unsigned CPAIR [9][4] = '{
		'{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
		'{7, 2, 8, 1}, '{8, 0, 6, 2}, '{6, 1, 7, 0},
		'{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
	};

	typedef logic signed [EW-1:0] elem_t;
	typedef logic signed [CW-1:0] cof_t;

	// What one divider lane needs to start.
	typedef struct packed {
		logic [MW-1:0] cm;
		logic          neg;
		logic          sat;
	} lane_in_t;

	typedef struct packed {
		logic [8:0][EW-1:0] inv;
		logic               invertible;
	} res_t;
endpackage
`default_nettype wire

// ===== src/mi3_front.sv =====
`default_nettype none
module mi3_front (
	input  wire logic                   clk,
	input  wire logic                   go,
	input  wire mi3_pkg::elem_t         m [9],
	input  wire logic [mi3_pkg::TW-1:0] thr,
	output logic [mi3_pkg::AW-1:0]      dmag,
	output logic                        inv,
	output mi3_pkg::lane_in_t           ln [9]
);
	logic signed [mi3_pkg::CW-1:0] p_s1 [18];
	mi3_pkg::elem_t                r0_s1 [3];
	mi3_pkg::elem_t                r0_s2 [3];
	mi3_pkg::cof_t                 cof_s2 [9];
	mi3_pkg::cof_t                 cof_s3 [9];
	mi3_pkg::cof_t                 cof_s4 [9];
	logic signed [64:0]            plo_s3 [3];
	logic signed [63:0]            phi_s3 [3];
	logic signed [mi3_pkg::DW-1:0] d_s4;
	logic [mi3_pkg::AW-1:0]        dmag_s5;
	logic                          dneg_s5;
	logic [mi3_pkg::MW-1:0]        cm_s5 [9];
	logic                          cneg_s5 [9];
	logic [mi3_pkg::AW-1:0]        dmag_s6;
	logic                          inv_s6;
	mi3_pkg::lane_in_t             ln_s6 [9];
	logic signed [mi3_pkg::DW-1:0] d_sum;
	logic [mi3_pkg::DW-1:0]        d_neg;

	// Stage 1: the eighteen 32x32 products of the cross products.
	for (genvar r = 0; r < 9; r++) begin : g_prod
		always_ff @(posedge clk) begin
			if (go) begin
				p_s1[2*r]   <= m[mi3_pkg::CPAIR[r][0]] * m[mi3_pkg::CPAIR[r][1]];
				p_s1[2*r+1] <= m[mi3_pkg::CPAIR[r][2]] * m[mi3_pkg::CPAIR[r][3]];
			end
		end
	end

	// Stages 1 to 4: row 0 delay, cofactors, determinant partial products and sum.
	always_ff @(posedge clk) begin
		if (go) begin
			for (int t = 0; t < 3; t++) begin
				r0_s1[t]  <= m[t];
				r0_s2[t]  <= r0_s1[t];
				plo_s3[t] <= r0_s2[t] * $signed({1'b0, cof_s2[t][31:0]});
				phi_s3[t] <= r0_s2[t] * $signed(cof_s2[t][63:32]);
			end
			for (int r = 0; r < 9; r++) begin
				cof_s2[r] <= p_s1[2*r] - p_s1[2*r+1];
				cof_s3[r] <= cof_s2[r];
				cof_s4[r] <= cof_s3[r];
			end
			d_s4 <= d_sum;
		end
	end

	// Determinant as the sum of high and low halves of each dot product term.
	always_comb begin
		d_sum = '0;
		for (int t = 0; t < 3; t++) begin
			d_sum = d_sum + $signed({{2{phi_s3[t][63]}}, phi_s3[t], 32'b0})
				+ $signed({{33{plo_s3[t][64]}}, plo_s3[t]});
		end
	end

	assign d_neg = -d_s4;

	// Stage 5: magnitudes of the determinant and of every cofactor.
	always_ff @(posedge clk) begin
		if (go) begin
			dneg_s5 <= d_s4[mi3_pkg::DW-1];
			dmag_s5 <= d_s4[mi3_pkg::DW-1] ? d_neg[mi3_pkg::AW-1:0]
				: d_s4[mi3_pkg::AW-1:0];
			for (int r = 0; r < 9; r++) begin
				cneg_s5[r] <= cof_s4[r][mi3_pkg::CW-1];
				cm_s5[r]   <= cof_s4[r][mi3_pkg::CW-1]
					? mi3_pkg::MW'(-cof_s4[r]) : cof_s4[r][mi3_pkg::MW-1:0];
			end
		end
	end

	// Stage 6: threshold test and quotient overflow per lane.
	always_ff @(posedge clk) begin
		if (go) begin
			dmag_s6 <= dmag_s5;
			inv_s6  <= (dmag_s5 != '0) && (dmag_s5 >= {18'b0, thr, 16'b0});
			for (int r = 0; r < 9; r++) begin
				ln_s6[r].cm  <= cm_s5[r];
				ln_s6[r].neg <= cneg_s5[r] ^ dneg_s5;
				ln_s6[r].sat <= {34'b0, cm_s5[r]} >= dmag_s5;
			end
		end
	end

	assign dmag = dmag_s6;
	assign inv  = inv_s6;
	assign ln   = ln_s6;
endmodule
`default_nettype wire

// ===== src/mi3_div_lane.sv =====
`default_nettype none
module mi3_div_lane (
	input  wire logic                   clk,
	input  wire logic                   go,
	input  wire mi3_pkg::lane_in_t      ln,
	input  wire logic [mi3_pkg::AW-1:0] dmag [mi3_pkg::QB],
	output logic [mi3_pkg::EW-1:0]      res
);
	logic [mi3_pkg::RW-1:0] rem_s [mi3_pkg::QB+1];
	logic [mi3_pkg::QB-1:0] q_s   [mi3_pkg::QB+1];
	logic                   neg_s [mi3_pkg::QB+1];
	logic                   sat_s [mi3_pkg::QB+1];
	logic [mi3_pkg::QB-1:0] q_fin;

	// Dividend is the cofactor magnitude scaled by 2^32.
	assign rem_s[0] = {ln.cm, 32'b0};
	assign q_s[0]   = '0;
	assign neg_s[0] = ln.neg;
	assign sat_s[0] = ln.sat;

	// One restoring step per stage, most significant quotient bit first.
	for (genvar i = 0; i < mi3_pkg::QB; i++) begin : g_step
		localparam int B = mi3_pkg::QB - 1 - i;
		logic [128:0] diff;
		logic         ge;
		assign diff = {34'b0, rem_s[i]} - ({32'b0, dmag[i]} << B);
		assign ge   = !diff[128];
		always_ff @(posedge clk) begin
			if (go) begin
				rem_s[i+1] <= ge ? diff[mi3_pkg::RW-1:0] : rem_s[i];
				q_s[i+1]   <= q_s[i] | (mi3_pkg::QB'(ge) << B);
				neg_s[i+1] <= neg_s[i];
				sat_s[i+1] <= sat_s[i];
			end
		end
	end

	// Apply the sign and saturate to the signed 32-bit range.
	assign q_fin = q_s[mi3_pkg::QB];
	always_comb begin
		if (neg_s[mi3_pkg::QB]) begin
			if (sat_s[mi3_pkg::QB] || q_fin > 32'h8000_0000) res = 32'h8000_0000;
			else res = -q_fin;
		end else begin
			if (sat_s[mi3_pkg::QB] || q_fin > 32'h7FFF_FFFF) res = 32'h7FFF_FFFF;
			else res = q_fin;
		end
	end
endmodule
`default_nettype wire

// ===== src/matrix_inverse_3x3_top.sv =====
// 3x3 matrix inverse by the adjugate, signed Q16.16 in and out.
// Input channel: in_valid/in_stall with the nine elements m_rXcY, row-major.
// Output channel: out_valid/out_stall with inv_rXcY and invertible.
// A transaction moves when valid is high and stall is low at a clock edge.
// Throughput is one matrix per cycle while the pipeline is not held. A matrix
// passes 6 stages of products, cofactors and determinant, 32 stages of the
// per-lane restoring dividers (one quotient bit each), and the output
// register. Nine divider lanes run side by side, one per output.
// When the receiver stalls, a skid register takes one more result; once it
// is full the whole pipeline holds and in_stall is raised until it drains.
// Singular matrices (|det| below det_threshold in Q31.32, or det zero) give
// all-zero outputs with invertible low.
// APB port: det_threshold at address 0, 64-bit data, always ready.
// Reset empties the pipeline and sets det_threshold to 4295 (about 1e-6).
`default_nettype none
`include "assert_macros.svh"
module matrix_inverse_3x3_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] m_r0c0,
	input  wire logic [31:0] m_r0c1,
	input  wire logic [31:0] m_r0c2,
	input  wire logic [31:0] m_r1c0,
	input  wire logic [31:0] m_r1c1,
	input  wire logic [31:0] m_r1c2,
	input  wire logic [31:0] m_r2c0,
	input  wire logic [31:0] m_r2c1,
	input  wire logic [31:0] m_r2c2,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      inv_r0c0,
	output logic [31:0]      inv_r0c1,
	output logic [31:0]      inv_r0c2,
	output logic [31:0]      inv_r1c0,
	output logic [31:0]      inv_r1c1,
	output logic [31:0]      inv_r1c2,
	output logic [31:0]      inv_r2c0,
	output logic [31:0]      inv_r2c1,
	output logic [31:0]      inv_r2c2,
	output logic             invertible
);
	logic [mi3_pkg::TW-1:0] thr_q;
	logic                   cfg_wr;
	logic                   go;
	logic [mi3_pkg::NS-1:0] v_q;
	mi3_pkg::elem_t         m_in [9];
	logic [mi3_pkg::AW-1:0] dmag_d [mi3_pkg::QB];
	logic                   inv_d [mi3_pkg::QB+1];
	mi3_pkg::lane_in_t      ln [9];
	logic [mi3_pkg::EW-1:0] lane_res [9];
	mi3_pkg::res_t          res;
	mi3_pkg::res_t          out_q;
	mi3_pkg::res_t          skid_q;
	logic                   out_v_q;
	logic                   skid_v_q;

	// Configuration register.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[3] == mi3_pkg::ADDR_THR);
	assign prdata = (paddr[3] == mi3_pkg::ADDR_THR) ? {1'b0, thr_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mi3_pkg::THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[mi3_pkg::TW-1:0];
		end
	end

	// The pipeline moves as a whole while the skid register is empty.
	assign go       = !skid_v_q;
	assign in_stall = skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (go) begin
			v_q <= {v_q[mi3_pkg::NS-2:0], in_valid};
		end
	end

	assign m_in = '{m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
		m_r2c0, m_r2c1, m_r2c2};

	mi3_front u_front (
		.clk  (clk),
		.go   (go),
		.m    (m_in),
		.thr  (thr_q),
		.dmag (dmag_d[0]),
		.inv  (inv_d[0]),
		.ln   (ln)
	);

	// Shared determinant magnitude and invertible flag, one copy per stage.
	for (genvar i = 1; i < mi3_pkg::QB; i++) begin : g_dmag
		always_ff @(posedge clk) begin
			if (go) dmag_d[i] <= dmag_d[i-1];
		end
	end
	for (genvar i = 0; i < mi3_pkg::QB; i++) begin : g_inv
		always_ff @(posedge clk) begin
			if (go) inv_d[i+1] <= inv_d[i];
		end
	end

	// Output row j, column k divides cofactor k element j.
	for (genvar n = 0; n < 9; n++) begin : g_lane
		localparam int J = n / 3;
		localparam int K = n % 3;
		mi3_div_lane u_lane (
			.clk  (clk),
			.go   (go),
			.ln   (ln[K*3+J]),
			.dmag (dmag_d),
			.res  (lane_res[n])
		);
		assign res.inv[n] = inv_d[mi3_pkg::QB] ? lane_res[n] : '0;
	end
	assign res.invertible = inv_d[mi3_pkg::QB];

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!out_stall) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end
		end else if (out_v_q && out_stall) begin
			skid_v_q <= v_q[mi3_pkg::NS-1];
		end else begin
			out_v_q <= v_q[mi3_pkg::NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_stall) out_q <= skid_q;
		end else if (out_v_q && out_stall) begin
			skid_q <= res;
		end else begin
			out_q <= res;
		end
	end

	assign out_valid  = out_v_q;
	assign inv_r0c0   = out_q.inv[0];
	assign inv_r0c1   = out_q.inv[1];
	assign inv_r0c2   = out_q.inv[2];
	assign inv_r1c0   = out_q.inv[3];
	assign inv_r1c1   = out_q.inv[4];
	assign inv_r1c2   = out_q.inv[5];
	assign inv_r2c0   = out_q.inv[6];
	assign inv_r2c1   = out_q.inv[7];
	assign inv_r2c2   = out_q.inv[8];
	assign invertible = out_q.invertible;

	// A held skid entry always has a result in front of it.
	`A_CHK(a_skid_behind_out, in_stall |-> out_valid)
	// The skid register only fills when the receiver stalled a result.
	`A_CHK(a_skid_fill, $rose(in_stall) |-> $past(out_valid && out_stall))
	// A singular result carries all-zero elements.
	`A_CHK(a_singular_zero, (out_valid && !invertible) |-> (out_q.inv == '0))
	// A threshold write lands in the register.
	`A_CHK(a_thr_write, cfg_wr |=> (thr_q == $past(pwdata[mi3_pkg::TW-1:0])))
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

module testbench;
	localparam logic [3:0] THR_ADDR = 4'h0;
	localparam logic [62:0] THR_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;

	// Kinds of random matrices.
	typedef enum int {
		MK_WELL, MK_FULL, MK_SINGULAR, MK_TINY, MK_EXTREME
	} mat_kind_e;

	typedef logic signed [31:0] mat_t [9];

	typedef struct packed {
		logic [8:0][31:0] inv;
		logic             invertible;
	} inverse_t;

	// Scoreboard: computes the expected inverse of each accepted matrix
	// and compares it with what leaves the block.
	class inverse_scoreboard;
		logic [62:0] thr;
		inverse_t    pending_q [$];
		int          mismatches;

		function void note_matrix(mat_t m);
			pending_q.push_back(invert(m));
		endfunction

		function inverse_t invert(mat_t m);
			int unsigned pairs [9][4];
			logic signed [65:0] cf [9];
			logic signed [65:0] p1;
			logic signed [65:0] p2;
			logic signed [127:0] det;
			logic signed [127:0] wide;
			logic [127:0] dmag;
			logic [127:0] cmag;
			logic [127:0] quo;
			logic [127:0] limit;
			logic neg;
			inverse_t r;
			pairs = '{'{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
				'{7, 2, 8, 1}, '{8, 0, 6, 2}, '{6, 1, 7, 0},
				'{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}};
			// Cofactors as cross products of row pairs, exact.
			for (int i = 0; i < 9; i++) begin
				p1 = m[pairs[i][0]];
				p1 = p1 * m[pairs[i][1]];
				p2 = m[pairs[i][2]];
				p2 = p2 * m[pairs[i][3]];
				cf[i] = p1 - p2;
			end
			// Determinant in Q48.48.
			det = 0;
			for (int i = 0; i < 3; i++) begin
				wide = m[i];
				wide = wide * cf[i];
				det = det + wide;
			end
			dmag = det < 0 ? -det : det;
			limit = {49'd0, thr, 16'd0};
			r = '0;
			if (dmag == 0 || dmag < limit)
				return r;
			r.invertible = 1'b1;
			// Output (j, k) is cofactor (k, j) over the determinant, truncated.
			for (int j = 0; j < 3; j++) begin
				for (int k = 0; k < 3; k++) begin
					wide = cf[k * 3 + j];
					cmag = wide < 0 ? -wide : wide;
					neg = (wide < 0) != (det < 0);
					quo = (cmag << 32) / dmag;
					if (neg)
						r.inv[j * 3 + k] = quo > 128'h8000_0000 ? 32'h8000_0000 : -quo[31:0];
					else
						r.inv[j * 3 + k] = quo > 128'h7FFF_FFFF ? 32'h7FFF_FFFF : quo[31:0];
				end
			end
			return r;
		endfunction

		function void check_inverse(inverse_t got);
			inverse_t exp_r;
			bit bad;
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result transaction", $realtime);
				return;
			end
			exp_r = pending_q.pop_front();
			bad = 0;
			for (int i = 0; i < 9; i++)
				if (got.inv[i] !== exp_r.inv[i]) begin
					bad = 1;
					if (mismatches < 10)
						$display("%0t: inv r%0dc%0d expected %h got %h", $realtime,
							i / 3, i % 3, exp_r.inv[i], got.inv[i]);
				end
			if (got.invertible !== exp_r.invertible) begin
				bad = 1;
				if (mismatches < 10)
					$display("%0t: invertible expected %b got %b", $realtime,
						exp_r.invertible, got.invertible);
			end
			if (bad)
				mismatches++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [31:0] m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2;
	logic out_valid, out_stall;
	logic [31:0] inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1, inv_r1c2;
	logic [31:0] inv_r2c0, inv_r2c1, inv_r2c2;
	logic invertible;

	inverse_scoreboard sb = new();
	bit quiet;
	int watchdog;
	int stall_left;

	matrix_inverse_3x3_top i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Check every result transaction.
	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_inverse({{inv_r2c2, inv_r2c1, inv_r2c0, inv_r1c2, inv_r1c1, inv_r1c0,
				inv_r0c2, inv_r0c1, inv_r0c0}, invertible});

	// Receiver stalls at random after each transaction, except in quiet phases.
	always @(posedge clk)
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (arst_n && out_valid && !out_stall)
				stall_left = quiet ? 0 : $urandom_range(0, 3);
		end

	// Watchdog on cycles with no transaction at all.
	always @(posedge clk)
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
				watchdog <= 0;
			else if (watchdog >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end else
				watchdog <= watchdog + 1;
		end

	task automatic write_threshold(input logic [62:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= THR_ADDR;
		pwdata <= {1'b0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.thr = value;
	endtask

	task automatic send_matrix(input mat_t m);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		{m_r0c0, m_r0c1, m_r0c2} <= {m[0], m[1], m[2]};
		{m_r1c0, m_r1c1, m_r1c2} <= {m[3], m[4], m[5]};
		{m_r2c0, m_r2c1, m_r2c2} <= {m[6], m[7], m[8]};
		do
			@(posedge clk);
		while (in_stall);
		sb.note_matrix(m);
	endtask

	function automatic logic signed [31:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2: return 0;
			3: return 32'sh0001_0000;
			4: return -32'sh0001_0000;
			default: return $urandom_range(0, 1) ? 1 : -1;
		endcase
	endfunction

	function automatic mat_t random_matrix(mat_kind_e kind);
		mat_t m;
		int row;
		for (int i = 0; i < 9; i++)
			case (kind)
				MK_WELL: m[i] = $signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000;
				MK_TINY: m[i] = $signed($urandom_range(0, 512)) - 256;
				MK_EXTREME: m[i] = pick_extreme();
				default: m[i] = $urandom;
			endcase
		if (kind == MK_WELL)
			for (int i = 0; i < 3; i++)
				m[i * 4] = m[i * 4] + ($urandom_range(0, 1) ? 32'sh8_0000 : -32'sh8_0000);
		if (kind == MK_SINGULAR) begin
			// The next row copies a row, each element zeroed at random; a full copy or a zero row makes the determinant zero.
			row = $urandom_range(0, 2);
			for (int c = 0; c < 3; c++)
				m[((row + 1) % 3) * 3 + c] = $urandom_range(0, 3) == 0 ? 0 : m[row * 3 + c];
		end
		return m;
	endfunction

	function automatic mat_t diag(logic signed [31:0] a, logic signed [31:0] b,
		logic signed [31:0] c);
		mat_t m;
		m = '{a, 0, 0, 0, b, 0, 0, 0, c};
		return m;
	endfunction

	// Stop sending, then wait until every accepted matrix has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [62:0] thresholds [6];
		mat_t directed [$];
		mat_t m;
		int w;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		out_stall <= 1'b0;
		{m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2} <= '0;
		watchdog <= 0;
		stall_left = 0;
		quiet = 0;
		sb.thr = mi3_pkg::THR_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed matrices under the reset threshold.
		directed.push_back(diag(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
		directed.push_back(diag(0, 0, 0));
		directed.push_back('{default: 32'sh7FFF_FFFF});
		directed.push_back('{default: 32'sh8000_0000});
		directed.push_back(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
		directed.push_back(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
		directed.push_back(diag(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sh1));
		directed.push_back(diag(1, 1, 1));
		directed.push_back(diag(32'sh100, 32'sh100, 32'sh100));
		directed.push_back(diag(32'sh1000, 32'sh1000, -32'sh1000));
		// Determinant exactly at, and just under, the threshold.
		directed.push_back(diag(4295, 32'sh1_0000, 1));
		directed.push_back(diag(-4295, 32'sh1_0000, 1));
		directed.push_back(diag(4294, 32'sh1_0000, 1));
		directed.push_back('{1, 2, 3, 4, 5, 6, 7, 8, 9});
		directed.push_back('{32'sh1_0000, 32'sh2_0000, 0, 32'sh1_0000, 32'sh2_0000, 5, 0, 0, 7});
		directed.push_back('{0, 32'sh1_0000, 0, 0, 0, 32'sh1_0000, 32'sh1_0000, 0, 0});
		directed.push_back('{32'sh2_0000, -32'sh1_0000, 0, -32'sh1_0000, 32'sh2_0000,
			-32'sh1_0000, 0, -32'sh1_0000, 32'sh2_0000});
		foreach (directed[i])
			send_matrix(directed[i]);
		wait_drained();

		// Random phases, each under its own threshold setting.
		thresholds = '{mi3_pkg::THR_RESET, 63'd0, THR_MAX, 63'd1, 63'd4295,
			63'd1 << $urandom_range(0, 62)};
		for (int p = 0; p < 6; p++) begin
			if (p > 0)
				write_threshold(thresholds[p]);
			quiet = (p % 3 == 2);
			for (int n = 0; n < 105; n++) begin
				w = $urandom_range(0, 99);
				if (w < 35) m = random_matrix(MK_WELL);
				else if (w < 55) m = random_matrix(MK_FULL);
				else if (w < 70) m = random_matrix(MK_SINGULAR);
				else if (w < 85) m = random_matrix(MK_TINY);
				else m = random_matrix(MK_EXTREME);
				send_matrix(m);
			end
			wait_drained();
		end

		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

`default_nettype wire
